>>> src/sobel_edge_pixel_counter_defines.svh
`ifndef SOBEL_EDGE_PIXEL_COUNTER_DEFINES_SVH
`define SOBEL_EDGE_PIXEL_COUNTER_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define SEPC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-qualified.
`define SEPC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sepc_pkg.sv
package sepc_pkg;

    localparam int unsigned DIM_W       = 12;
    localparam int unsigned THR_W       = 11;
    localparam int unsigned CNT_W       = 22;
    localparam int unsigned LUMA_W      = 8;
    localparam int unsigned SUM_W       = 18;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam logic [DIM_W-1:0] RST_WIDTH     = 12'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT    = 12'd480;
    localparam logic [THR_W-1:0] RST_THRESHOLD = 11'd30;

    // luma = (299R + 587G + 114B) / 1000 = ((sum >> 3) * 33555) >> 22
    localparam int unsigned LUMA_WR     = 299;
    localparam int unsigned LUMA_WG     = 587;
    localparam int unsigned LUMA_WB     = 114;
    localparam int unsigned LUMA_PRE    = 3;
    localparam int unsigned LUMA_RECIP  = 33555;
    localparam int unsigned RECIP_W     = 16;
    localparam int unsigned LUMA_SHIFT  = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic              valid;
        logic [LUMA_W-1:0] luma;
    } luma_beat_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [THR_W-1:0] threshold;
    } frame_cfg_t;

endpackage

>>> src/sepc_luma.sv
module sepc_luma (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    output sepc_pkg::luma_beat_t beat_o
);
    import sepc_pkg::*;

    localparam int unsigned Q_W    = SUM_W - LUMA_PRE;
    localparam int unsigned PROD_W = Q_W + RECIP_W;

    logic              v1_reg;
    logic [7:0]        r1_reg;
    logic [7:0]        g1_reg;
    logic [7:0]        b1_reg;
    logic              v2_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              v3_reg;
    logic [LUMA_W-1:0] luma_reg;
    logic [LUMA_W-1:0] luma_next;
    logic [PROD_W-1:0] quot;

    assign sum_next = SUM_W'(r1_reg) * SUM_W'(LUMA_WR)
                    + SUM_W'(g1_reg) * SUM_W'(LUMA_WG)
                    + SUM_W'(b1_reg) * SUM_W'(LUMA_WB);

    assign quot      = PROD_W'(sum_reg[SUM_W-1:LUMA_PRE]) * PROD_W'(LUMA_RECIP);
    assign luma_next = quot[LUMA_SHIFT +: LUMA_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg   <= red;
            g1_reg   <= green;
            b1_reg   <= blue;
            sum_reg  <= sum_next;
            luma_reg <= luma_next;
        end
    end

    assign beat_o.valid = v3_reg;
    assign beat_o.luma  = luma_reg;

endmodule

>>> src/sepc_frame.sv
module sepc_frame #(
    parameter int unsigned MAX_WIDTH  = sepc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = sepc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sepc_pkg::luma_beat_t         beat_i,
    input  sepc_pkg::frame_cfg_t         cfg_i,
    input  logic                         m_ready,
    output logic                         en,
    output logic                         m_valid,
    output logic [sepc_pkg::CNT_W-1:0]   edge_count,
    output logic [sepc_pkg::CNT_W-1:0]   interior_pixels
);
    import sepc_pkg::*;

    localparam int unsigned CW     = $clog2(MAX_WIDTH);
    localparam int unsigned RW     = $clog2(MAX_HEIGHT);
    localparam int unsigned WORD_W = 2 * LUMA_W;
    localparam int unsigned G_W    = 11;
    localparam int unsigned MAG_W  = 12;
    localparam int unsigned IP_W   = 2 * DIM_W;

    logic [WORD_W-1:0] line_mem [MAX_WIDTH];

    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_reg;
    logic [CNT_W-1:0]  edges_reg;
    logic [LUMA_W-1:0] win_reg [6];
    logic [WORD_W-1:0] rd_reg;
    logic              byp_reg;
    logic [WORD_W-1:0] byp_data_reg;
    logic [CNT_W-1:0]  interior_reg;
    logic [IP_W-1:0]   interior_prod;
    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_edge_reg;
    logic [CNT_W-1:0]  m_int_reg;

    logic [WORD_W-1:0] store_word;
    logic [LUMA_W-1:0] above;
    logic [LUMA_W-1:0] two_above;
    logic              row_end;
    logic              frame_end;
    logic              inner_pos;
    logic              advance;
    logic signed [G_W-1:0] gx;
    logic signed [G_W-1:0] gy;
    logic [G_W-1:0]    abs_gx;
    logic [G_W-1:0]    abs_gy;
    logic [MAG_W-1:0]  mag;
    logic              edge_hit;
    logic [CNT_W-1:0]  edges_inc;

    function automatic logic signed [G_W-1:0] sx(input logic [LUMA_W-1:0] v);
        sx = $signed({{(G_W-LUMA_W){1'b0}}, v});
    endfunction

    assign store_word = byp_reg ? byp_data_reg : rd_reg;
    assign above      = store_word[LUMA_W-1:0];
    assign two_above  = store_word[WORD_W-1:LUMA_W];

    assign row_end   = (32'(col_reg) + 32'd1) >= 32'(cfg_i.width);
    assign frame_end = row_end && ((32'(row_reg) + 32'd1) >= 32'(cfg_i.height));
    assign inner_pos = (32'(col_reg) >= 32'd2) && (32'(row_reg) >= 32'd2);
    assign col_next  = row_end ? '0 : col_reg + 1'b1;

    // columns: [0..2] = c-2 (top, mid, bottom), [3..5] = c-1
    assign gx = (sx(two_above) - sx(win_reg[0]))
              + ((sx(above) - sx(win_reg[1])) <<< 1)
              + (sx(beat_i.luma) - sx(win_reg[2]));
    assign gy = (sx(win_reg[2]) - sx(win_reg[0]))
              + ((sx(win_reg[5]) - sx(win_reg[3])) <<< 1)
              + (sx(beat_i.luma) - sx(two_above));
    assign abs_gx   = gx[G_W-1] ? G_W'(-gx) : G_W'(gx);
    assign abs_gy   = gy[G_W-1] ? G_W'(-gy) : G_W'(gy);
    assign mag      = MAG_W'(abs_gx) + MAG_W'(abs_gy);
    assign edge_hit = inner_pos && (mag > MAG_W'(cfg_i.threshold));
    assign edges_inc = edges_reg + CNT_W'(edge_hit);

    assign en      = !(beat_i.valid && frame_end && m_valid_reg && !m_ready);
    assign advance = en && beat_i.valid;

    assign interior_prod = IP_W'(cfg_i.width - DIM_W'(2)) * IP_W'(cfg_i.height - DIM_W'(2));

    always_ff @(posedge aclk) begin
        if (advance) begin
            line_mem[col_reg] <= {above, beat_i.luma};
            rd_reg            <= line_mem[col_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            edges_reg   <= '0;
            byp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= two_above;
                win_reg[4] <= above;
                win_reg[5] <= beat_i.luma;
                // width of one: next read hits the entry written now
                byp_reg    <= (col_next == col_reg);
                col_reg    <= col_next;
                if (frame_end) begin
                    row_reg     <= '0;
                    edges_reg   <= '0;
                    m_valid_reg <= 1'b1;
                end else begin
                    edges_reg <= edges_inc;
                    if (row_end) begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((cfg_i.width >= DIM_W'(3)) && (cfg_i.height >= DIM_W'(3))) begin
            interior_reg <= interior_prod[CNT_W-1:0];
        end else begin
            interior_reg <= '0;
        end
        if (advance) begin
            byp_data_reg <= {above, beat_i.luma};
        end
        if (advance && frame_end) begin
            m_edge_reg <= edges_inc;
            m_int_reg  <= interior_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign edge_count      = m_edge_reg;
    assign interior_pixels = m_int_reg;

endmodule

>>> src/sobel_edge_pixel_counter.sv
// Sobel edge pixel counter. Takes one RGB pixel per clock in raster order and
// returns one transfer per frame, on the frame's last pixel, holding the count of
// interior pixels whose |gx|+|gy| exceeds edge_threshold and the interior pixel
// count (width-2)*(height-2), both zero for images narrower or shorter than 3.
// Each pixel passes an input register, a weighted-sum register, a luma register
// (reciprocal multiply for the /1000) and the window/count stage, which registers
// the frame result. The two rows above are kept in one MAX_WIDTH x 16 line
// memory, prefetched one column ahead. Sustained rate is one pixel per clock;
// s_axis_tready drops only while a new frame result meets an earlier one that
// m_axis has not yet taken. Configuration takes effect at once and should be
// written between frames.
`include "sobel_edge_pixel_counter_defines.svh"

module sobel_edge_pixel_counter #(
    parameter int unsigned MAX_WIDTH  = sepc_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = sepc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sepc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sepc_pkg::DIM_W-1:0]         cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // red, green, blue
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [47:0]                        m_axis_tdata   // edge_count, interior_pixels
);
    import sepc_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] threshold_reg;
    frame_cfg_t       frame_cfg;
    luma_beat_t       luma_beat;
    logic             pipe_en;
    logic [CNT_W-1:0] edge_count;
    logic [CNT_W-1:0] interior_pixels;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned    max_v);
        if (v == '0) begin
            clamp_dim = DIM_W'(1);
        end else if (32'(v) > max_v) begin
            clamp_dim = DIM_W'(max_v);
        end else begin
            clamp_dim = v;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            threshold_reg <= RST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata;
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata;
                end
                REG_EDGE_THRESHOLD: begin
                    threshold_reg <= cfg_wdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign frame_cfg.width     = clamp_dim(width_reg, MAX_WIDTH);
    assign frame_cfg.height    = clamp_dim(height_reg, MAX_HEIGHT);
    assign frame_cfg.threshold = threshold_reg;

    sepc_luma u_luma (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s_axis_tvalid),
        .red      (s_axis_tdata[7:0]),
        .green    (s_axis_tdata[15:8]),
        .blue     (s_axis_tdata[23:16]),
        .beat_o   (luma_beat)
    );

    sepc_frame #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .beat_i          (luma_beat),
        .cfg_i           (frame_cfg),
        .m_ready         (m_axis_tready),
        .en              (pipe_en),
        .m_valid         (m_axis_tvalid),
        .edge_count      (edge_count),
        .interior_pixels (interior_pixels)
    );

    assign s_axis_tready = pipe_en;
    assign m_axis_tdata  = {4'b0, interior_pixels, edge_count};

    `SEPC_ASSERT_IMPL(a_stall_only_on_blocked_result, aclk, aresetn,
        !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")
    `SEPC_ASSERT_NEXT(a_no_result_from_empty_pipe, aclk, aresetn,
        !luma_beat.valid && !m_axis_tvalid, !m_axis_tvalid, "result without a pixel behind it")
    `SEPC_ASSERT_IMPL(a_result_follows_pixel, aclk, aresetn,
        $rose(m_axis_tvalid), $past(luma_beat.valid), "result loaded with no luma beat")

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sepc_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned RANDOM_PIXELS = 750;
    localparam logic [CNT_W-1:0] CNT_MASK = '1;

    // packed so that red lands in the low byte of tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [CNT_W-1:0] interior;
        logic [CNT_W-1:0] edges;
    } frame_total_t;

    typedef enum int {
        SCENE_NOISE,
        SCENE_FLAT,
        SCENE_STEP,
        SCENE_RAMP
    } scene_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_reg_e    cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // red, green, blue
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // edge_count, interior_pixels

    sobel_edge_pixel_counter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic [DIM_W-1:0] cfg_width  = RST_WIDTH;
    logic [DIM_W-1:0] cfg_height = RST_HEIGHT;
    logic [THR_W-1:0] cfg_thr    = RST_THRESHOLD;
    logic [7:0]       line_above     [DEF_MAX_WIDTH];
    logic [7:0]       line_two_above [DEF_MAX_WIDTH];
    logic [7:0]       win [6];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [CNT_W-1:0] edge_tally = '0;

    rgb_t         pixel_q[$];
    frame_total_t frame_totals_q[$];

    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0;
    int unsigned frames_checked = 0;
    int unsigned edges_seen = 0;
    int unsigned reg_writes = 0;

    int unsigned src_gap = 0;
    int unsigned src_run_left = 0;
    int unsigned snk_gap = 0;
    int unsigned snk_run_left = 0;

    scene_e      scene;
    int unsigned scene_lo, scene_hi, scene_split, scene_dx, scene_dy;
    bit          scene_vertical;

    initial begin
        foreach (line_above[i]) begin
            line_above[i] = '0;
            line_two_above[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
    end

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned max_dim);
        if (v == 0) return 1;
        if (v > max_dim) return max_dim;
        return v;
    endfunction

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void predict_pixel(rgb_t px);
        int unsigned w, h, luma, col;
        int gx, gy;
        logic [7:0] above, two_above;
        bit row_end, frame_end;
        frame_total_t tot;
        w = eff_dim(cfg_width, DEF_MAX_WIDTH);
        h = eff_dim(cfg_height, DEF_MAX_HEIGHT);
        luma = (px.red * 299 + px.green * 587 + px.blue * 114) / 1000;
        col = (col_pos < DEF_MAX_WIDTH) ? col_pos : DEF_MAX_WIDTH - 1;
        above = line_above[col];
        two_above = line_two_above[col];
        row_end = col_pos >= w - 1;
        frame_end = row_end && row_pos >= h - 1;
        if (col_pos >= 2 && row_pos >= 2) begin
            gx = -int'(win[0]) + int'(two_above) - 2 * int'(win[1]) + 2 * int'(above)
                 - int'(win[2]) + int'(luma);
            gy = -int'(win[0]) - 2 * int'(win[3]) - int'(two_above) + int'(win[2])
                 + 2 * int'(win[5]) + int'(luma);
            if (iabs(gx) + iabs(gy) > int'(cfg_thr)) edge_tally = edge_tally + 1'b1;
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = two_above;
        win[4] = above;
        win[5] = luma[7:0];
        line_two_above[col] = above;
        line_above[col] = luma[7:0];
        if (frame_end) begin
            tot.edges = edge_tally;
            tot.interior = (w >= 3 && h >= 3) ? CNT_MASK & CNT_W'((w - 2) * (h - 2)) : '0;
            frame_totals_q.push_back(tot);
            col_pos = 0;
            row_pos = 0;
            edge_tally = '0;
        end else if (row_end) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // source
    always @(posedge aclk) begin
        bit nxt_valid;
        logic [23:0] nxt_data;
        nxt_valid = s_axis_tvalid && !s_axis_tready;
        nxt_data = s_axis_tdata;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!nxt_valid) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (pixel_q.size() > 0) begin
                nxt_data = pixel_q.pop_front();
                nxt_valid = 1'b1;
                if (src_run_left > 0) begin
                    src_run_left--;
                end else if ($urandom_range(0, 99) < 3) begin
                    src_run_left = $urandom_range(30, 150);
                end else begin
                    src_gap = pick_gap();
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
    end

    // sink
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (snk_run_left > 0) begin
                snk_run_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                snk_run_left = $urandom_range(50, 300);
            end else if ($urandom_range(0, 99) < 20) begin
                snk_gap = pick_gap();
            end
        end
    end

    // monitor: results first, then the pixel taken at this edge
    always @(posedge aclk) begin
        frame_total_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_totals_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected result transfer, tdata %h", m_axis_tdata);
                end else begin
                    want = frame_totals_q.pop_front();
                    frames_checked++;
                    edges_seen += want.edges;
                    if (m_axis_tdata !== {4'b0, want}) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: frame %0d: edge_count exp %0d got %0d, %s %0d got %0d%s",
                                     frames_checked, want.edges, m_axis_tdata[21:0],
                                     "interior_pixels exp", want.interior,
                                     m_axis_tdata[43:22],
                                     (m_axis_tdata[47:44] !== 4'b0) ? ", pad bits set" : "");
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(rgb_t'(s_axis_tdata));
                pixels_sent++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycles, frame_totals_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] clip8(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic rgb_t gray(int v);
        rgb_t px;
        px.red = clip8(v);
        px.green = clip8(v);
        px.blue = clip8(v);
        return px;
    endfunction

    function automatic rgb_t jitter(int v, int amount);
        rgb_t px;
        px.red = clip8(v + $urandom_range(0, amount));
        px.green = clip8(v + $urandom_range(0, amount));
        px.blue = clip8(v + $urandom_range(0, amount));
        return px;
    endfunction

    function automatic rgb_t make_pixel(int unsigned x, int unsigned y);
        case (scene)
            SCENE_NOISE: return rgb_t'(24'($urandom));
            SCENE_FLAT:  return jitter(scene_lo, 3);
            SCENE_STEP:  return jitter(((scene_vertical ? x : y) >= scene_split) ?
                                       scene_hi : scene_lo, 2);
            default:     return gray((scene_lo + scene_dx * x + scene_dy * y) % 256);
        endcase
    endfunction

    // one whole frame at the current geometry, with random content
    task automatic push_frame(ref int unsigned pushed);
        int unsigned w, h;
        w = eff_dim(cfg_width, DEF_MAX_WIDTH);
        h = eff_dim(cfg_height, DEF_MAX_HEIGHT);
        scene = scene_e'($urandom_range(0, 3));
        scene_lo = $urandom_range(0, 255);
        scene_hi = $urandom_range(0, 255);
        scene_split = $urandom_range(0, (w > h ? w : h));
        scene_vertical = $urandom_range(0, 1);
        scene_dx = $urandom_range(0, 40);
        scene_dy = $urandom_range(0, 40);
        for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++)
                pixel_q.push_back(make_pixel(x, y));
        pushed += w * h;
    endtask

    // block is idle only once all pixels are in and all totals are out
    task automatic settle();
        while (pixel_q.size() != 0 || s_axis_tvalid || frame_totals_q.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_e which, logic [DIM_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (which)
            REG_IMAGE_WIDTH:    cfg_width = value;
            REG_IMAGE_HEIGHT:   cfg_height = value;
            REG_EDGE_THRESHOLD: cfg_thr = value[THR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned thr);
        settle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        write_reg(REG_EDGE_THRESHOLD, DIM_W'(thr));
    endtask

    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 12);
        if (r < 92) return $urandom_range(13, 48);
        if (r < 96) return 0;
        return $urandom_range(49, 100);
    endfunction

    function automatic int unsigned pick_height();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 72) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 20);
        return 0;
    endfunction

    function automatic int unsigned pick_threshold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 100);
        if (r < 70) return $urandom_range(100, 600);
        if (r < 80) return 0;
        if (r < 90) return $urandom_range(2040, 2047);
        return $urandom_range(0, 4095);   // upper bit is dropped by the register
    endfunction

    initial begin
        int unsigned n;
        n = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // narrow column at reset height and threshold
        write_reg(REG_IMAGE_WIDTH, DIM_W'(1));
        push_frame(n);
        settle();
        write_reg(REG_IMAGE_WIDTH, DIM_W'(3));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(3));
        pixel_q.push_back(rgb_t'(24'h000000));
        pixel_q.push_back(rgb_t'(24'hffffff));
        pixel_q.push_back(rgb_t'(24'h0000ff));
        pixel_q.push_back(rgb_t'(24'h00ff00));
        pixel_q.push_back(rgb_t'(24'hff0000));
        pixel_q.push_back(rgb_t'(24'h00ffff));
        pixel_q.push_back(rgb_t'(24'hffff00));
        pixel_q.push_back(rgb_t'(24'hff00ff));
        pixel_q.push_back(rgb_t'(24'h000000));

        // magnitude exactly at the threshold, then one above it
        for (int unsigned thr = 40; thr >= 39; thr--) begin
            set_config(3, 3, thr);
            for (int unsigned i = 0; i < 9; i++) pixel_q.push_back(gray(i % 3 == 2 ? 10 : 0));
        end

        // every pixel ends a frame; zero dimensions act as one
        set_config(1, 1, 0);
        pixel_q.push_back(gray(255));
        pixel_q.push_back(gray(0));
        set_config(0, 0, 2047);
        pixel_q.push_back(gray(255));
        pixel_q.push_back(rgb_t'(24'h5a5a5a));
        set_config(2, 5, 0);
        push_frame(n);
        set_config(5, 2, 0);
        push_frame(n);

        n = 0;
        while (n < RANDOM_PIXELS) begin
            set_config(pick_width(), pick_height(), pick_threshold());
            repeat ($urandom_range(1, 4)) push_frame(n);
        end

        settle();
        repeat (20) @(posedge aclk);
        $display("tb: %0d pixels in, %0d frame totals checked, %0d edge pixels counted",
                 pixels_sent, frames_checked, edges_seen);
        $display("tb: %0d register writes incl. zero-size and max-threshold settings",
                 reg_writes);
        if (mismatches == 0 && frame_totals_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d mismatches", mismatches);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
